>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the curve point generator.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SFC_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sfcpg assertion failed");

// Concurrent assertion on the usual clk_i and rst_ni of a module.
`define SFC_ASSERT(name, prop) \
  `SFC_ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

>>> rtl/sfcpg_pkg.sv
// Shared types, constants and tables of the curve point generator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package sfcpg_pkg;

  // Configuration port geometry.
  localparam int CfgIdxW = 3;
  localparam int DepthW = 3;
  localparam logic [DepthW-1:0] DepthReset = 3'd3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RECT_LEFT   = 3'd0,
    CFG_RECT_TOP    = 3'd1,
    CFG_RECT_RIGHT  = 3'd2,
    CFG_RECT_BOTTOM = 3'd3,
    CFG_DEPTH       = 3'd4
  } cfg_idx_e;

  // Which halving of a corner pair a child corner takes.
  typedef enum logic [1:0] {
    HALF_FIRST,
    HALF_MID,
    HALF_SECOND
  } half_sel_e;

  // Child corner selection per table row.
  localparam half_sel_e HalfX1 [4] = '{HALF_FIRST, HALF_FIRST, HALF_MID, HALF_MID};
  localparam half_sel_e HalfY1 [4] = '{HALF_MID, HALF_FIRST, HALF_FIRST, HALF_MID};
  localparam half_sel_e HalfX2 [4] = '{HALF_MID, HALF_MID, HALF_SECOND, HALF_SECOND};
  localparam half_sel_e HalfY2 [4] = '{HALF_SECOND, HALF_MID, HALF_MID, HALF_SECOND};

  // Leaf vertex weighting: bit r set when row r weights the first corner by three.
  localparam logic [3:0] LeafXFirstHeavy = 4'b0011;
  localparam logic [3:0] LeafYFirstHeavy = 4'b0110;

  // Per child index: direction flip and rotation increment.
  localparam logic [3:0] FlipDir = 4'b1001;
  localparam logic [1:0] AddKind [4] = '{2'd0, 2'd0, 2'd0, 2'd2};

  // Controller states.
  typedef enum logic [1:0] {
    S_WAIT,
    S_DESCEND,
    S_EMIT,
    S_POP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic root_load;
    logic descend;
    logic pop_load;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_leaf;
    logic leaf_last;
    logic all_done;
  } dp_status_t;

  // Table row for child or leaf index i of a frame.
  function automatic logic [1:0] row_of(logic [1:0] kind, logic neg, logic [1:0] i);
    return neg ? (kind - i) : (kind + i);
  endfunction

endpackage

`default_nettype wire

>>> rtl/sfcpg_if.sv
// Valid/ready channel interfaces for the restart input and the point output.
// Depends on nothing; used by the top level of the curve point generator.
`default_nettype none

interface sfcpg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface sfcpg_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

`default_nettype wire

>>> rtl/space_filling_curve_point_generator_top.sv
// Curve point generator top level: one valid/ready restart input, one vertex output.
// A plain tick is accepted in S_WAIT and emitted into the output register in S_EMIT
// once that register is free. After every fourth vertex, unless the walk is done, it pops
// to the deepest level with a child left and re-descends; a restart loads the root and
// descends to its first vertex. Descent moves the frame stack one level per cycle.
// Reset (rst_ni, async low) idles the walk and loads the default rectangle and depth.
`default_nettype none

module space_filling_curve_point_generator_top import sfcpg_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int MAX_LEVELS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfcpg_in_if.sink              in_i,
  sfcpg_out_if.source           out_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing and handshakes.
  sfcpg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_restart_i (in_i.restart),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Frame stack and vertex arithmetic.
  sfcpg_dp #(
    .COORD_BITS (COORD_BITS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .point_x_o    (out_o.point_x),
    .point_y_o    (out_o.point_y),
    .last_point_o (out_o.last_point)
  );

endmodule

`default_nettype wire

>>> rtl/sfcpg_dp.sv
// Datapath: configuration registers, frame stack, child and vertex arithmetic.
// Depends on sfcpg_pkg; driven by commands from sfcpg_ctrl.
`default_nettype none

module sfcpg_dp import sfcpg_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int MAX_LEVELS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output logic [COORD_BITS-1:0] point_x_o,
  output logic [COORD_BITS-1:0] point_y_o,
  output logic                  last_point_o
);

  localparam int LevW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int MaxLev = MAX_LEVELS - 1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t     x1;
    coord_t     y1;
    coord_t     x2;
    coord_t     y2;
    logic [1:0] kind;
    logic       neg;
  } frame_t;

  // Halving of a corner pair.
  function automatic coord_t half_pick(half_sel_e sel, coord_t a, coord_t b);
    logic [COORD_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    unique case (sel)
      HALF_FIRST:  return a;
      HALF_MID:    return sum[COORD_BITS:1];
      HALF_SECOND: return b;
      default:     return a;
    endcase
  endfunction

  // Quarter position between two corners: (3*heavy + light) / 4.
  function automatic coord_t leaf_pick(logic first_heavy, coord_t a, coord_t b);
    coord_t              heavy;
    coord_t              light;
    logic [COORD_BITS+1:0] sum;
    heavy = first_heavy ? a : b;
    light = first_heavy ? b : a;
    sum = {2'b00, heavy} + {1'b0, heavy, 1'b0} + {2'b00, light};
    return sum[COORD_BITS+1:2];
  endfunction

  coord_t            rect_left_q, rect_top_q, rect_right_q, rect_bottom_q;
  logic [DepthW-1:0] depth_q;

  frame_t            cur_q;
  frame_t            stack_q [MAX_LEVELS];
  logic [1:0]        idx_q [MAX_LEVELS];
  logic [LevW-1:0]   lev_q;
  logic [LevW-1:0]   walk_depth_q;
  logic [1:0]        leaf_pos_q;

  coord_t            point_x_q, point_y_q;
  logic              last_q;

  frame_t            root;
  frame_t            child;
  logic [1:0]        child_idx;
  logic [1:0]        child_row;
  logic [1:0]        leaf_row;
  logic [LevW-1:0]   lev_next;
  logic [LevW-1:0]   walk_depth_cfg;
  logic [LevW-1:0]   pop_lev;
  logic              all_done;
  logic              leaf_last;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_left_q   <= '0;
      rect_top_q    <= '0;
      rect_right_q  <= COORD_BITS'(1023);
      rect_bottom_q <= COORD_BITS'(767);
      depth_q       <= DepthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RECT_LEFT:   rect_left_q   <= cfg_data_i;
        CFG_RECT_TOP:    rect_top_q    <= cfg_data_i;
        CFG_RECT_RIGHT:  rect_right_q  <= cfg_data_i;
        CFG_RECT_BOTTOM: rect_bottom_q <= cfg_data_i;
        CFG_DEPTH:       depth_q       <= cfg_data_i[DepthW-1:0];
        default:         ;
      endcase
    end
  end

  // Leaf level of a new walk, clamped to the stack.
  always_comb begin
    if (int'(depth_q) > MaxLev) begin
      walk_depth_cfg = LevW'(MaxLev);
    end else begin
      walk_depth_cfg = LevW'(depth_q);
    end
  end

  // Root frame from the configured rectangle.
  always_comb begin
    root.x1   = rect_left_q;
    root.y1   = rect_top_q;
    root.x2   = rect_right_q;
    root.y2   = rect_bottom_q;
    root.kind = 2'd0;
    root.neg  = 1'b0;
  end

  // Child rectangle of the current frame at its current child index.
  always_comb begin
    child_idx  = idx_q[lev_q];
    child_row  = row_of(cur_q.kind, cur_q.neg, child_idx);
    child.x1   = half_pick(HalfX1[child_row], cur_q.x1, cur_q.x2);
    child.y1   = half_pick(HalfY1[child_row], cur_q.y1, cur_q.y2);
    child.x2   = half_pick(HalfX2[child_row], cur_q.x1, cur_q.x2);
    child.y2   = half_pick(HalfY2[child_row], cur_q.y1, cur_q.y2);
    child.kind = cur_q.kind + AddKind[child_idx];
    child.neg  = cur_q.neg ^ FlipDir[child_idx];
  end

  assign lev_next = lev_q + LevW'(1);
  assign leaf_row = row_of(cur_q.kind, cur_q.neg, leaf_pos_q);
  assign leaf_last = (leaf_pos_q == 2'd3);

  // Deepest level above the leaf with a child still to visit.
  always_comb begin
    pop_lev  = '0;
    all_done = 1'b1;
    for (int l = 0; l < MAX_LEVELS; l++) begin
      if (l < int'(walk_depth_q) && idx_q[l] != 2'd3) begin
        pop_lev  = LevW'(l);
        all_done = 1'b0;
      end
    end
  end

  assign status_o.at_leaf   = (lev_q == walk_depth_q);
  assign status_o.leaf_last = leaf_last;
  assign status_o.all_done  = all_done;

  // Walk position registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lev_q        <= '0;
      walk_depth_q <= '0;
      leaf_pos_q   <= '0;
    end else begin
      if (cmd_i.root_load) begin
        walk_depth_q <= walk_depth_cfg;
        lev_q        <= '0;
        leaf_pos_q   <= '0;
      end else if (cmd_i.descend) begin
        lev_q <= lev_next;
      end else if (cmd_i.pop_load) begin
        lev_q      <= pop_lev;
        leaf_pos_q <= '0;
      end else if (cmd_i.emit && !leaf_last) begin
        leaf_pos_q <= leaf_pos_q + 2'd1;
      end
    end
  end

  // Frame stack, current frame and child indexes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_load) begin
      cur_q      <= root;
      stack_q[0] <= root;
      idx_q[0]   <= '0;
    end else if (cmd_i.descend) begin
      cur_q            <= child;
      stack_q[lev_next] <= child;
      idx_q[lev_next]   <= '0;
    end else if (cmd_i.pop_load) begin
      cur_q          <= stack_q[pop_lev];
      idx_q[pop_lev] <= idx_q[pop_lev] + 2'd1;
    end
  end

  // Output register for the emitted vertex.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      point_x_q <= leaf_pick(LeafXFirstHeavy[leaf_row], cur_q.x1, cur_q.x2);
      point_y_q <= leaf_pick(LeafYFirstHeavy[leaf_row], cur_q.y1, cur_q.y2);
      last_q    <= leaf_last && all_done;
    end
  end

  assign point_x_o    = point_x_q;
  assign point_y_o    = point_y_q;
  assign last_point_o = last_q;

endmodule

`default_nettype wire

>>> rtl/sfcpg_ctrl.sv
// Controller state machine: handshakes, walk sequencing and datapath commands.
// Depends on sfcpg_pkg and assert_macros.svh; pairs with sfcpg_dp.
`default_nettype none
`include "assert_macros.svh"

module sfcpg_ctrl import sfcpg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_restart_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   walk_active_q, walk_active_d;
  logic   first_q, first_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // State and flag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_WAIT;
      walk_active_q <= 1'b0;
      first_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      walk_active_q <= walk_active_d;
      first_q       <= first_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    walk_active_d = walk_active_q;
    first_d       = first_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_WAIT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_restart_i) begin
            cmd_o.root_load = 1'b1;
            walk_active_d   = 1'b1;
            first_d         = 1'b1;
            state_d         = S_DESCEND;
          end else if (walk_active_q) begin
            state_d = S_EMIT;
          end
        end
      end
      S_DESCEND: begin
        if (status_i.at_leaf) begin
          state_d = first_q ? S_EMIT : S_WAIT;
        end else begin
          cmd_o.descend = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (status_i.leaf_last && status_i.all_done) begin
            walk_active_d = 1'b0;
            state_d       = S_WAIT;
          end else if (status_i.leaf_last) begin
            state_d = S_POP;
          end else begin
            state_d = S_WAIT;
          end
        end
      end
      S_POP: begin
        cmd_o.pop_load = 1'b1;
        first_d        = 1'b0;
        state_d        = S_DESCEND;
      end
      default: begin
        state_d = S_WAIT;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // A vertex is only written into a free output register.
  `SFC_ASSERT(a_emit_slot_free, cmd_o.emit |-> (!out_valid_q || out_ready_i))
  // Descent stops at the leaf level.
  `SFC_ASSERT(a_no_descend_past_leaf, cmd_o.descend |-> !status_i.at_leaf)
  // The final vertex ends the walk.
  `SFC_ASSERT(a_final_ends_walk,
              (cmd_o.emit && status_i.leaf_last && status_i.all_done) |=> !walk_active_q)
  // Emission only happens inside an active walk.
  `SFC_ASSERT(a_emit_in_walk, (state_q == S_EMIT) |-> walk_active_q)

endmodule

`default_nettype wire
